FILE: rtl/crr_pkg.sv
// crr_pkg: shared types, constants and helpers for the character row renderer
// no dependencies; used by the interfaces and all rtl modules

package crr_pkg;

  localparam int unsigned GlyphWidth  = 6;
  localparam int unsigned RomDepth    = 4096;
  localparam int unsigned RomAddrW    = 12;
  localparam int unsigned RomDataW    = 8;
  localparam int unsigned CharCodeW   = 8;
  localparam int unsigned CharAddrW   = 11;
  localparam int unsigned ScanlineW   = 4;
  localparam int unsigned PixelW      = 2 * GlyphWidth;
  localparam int unsigned CfgIndexW   = 2;
  localparam int unsigned CfgDataW    = 11;

  // substituted scanlines
  localparam logic [ScanlineW-1:0] RowBlank  = 4'hE;
  localparam logic [ScanlineW-1:0] RowCursor = 4'hF;

  // rom byte and char code fields
  localparam int unsigned AttrCmdBit = 7;
  localparam int unsigned AttrValBit = 6;
  localparam int unsigned InverseBit = 7;

  typedef enum logic [1:0] {
    KIND_PIXELS = 2'd0,
    KIND_ATTR   = 2'd1,
    KIND_SKIP   = 2'd2
  } cell_kind_e;

  typedef enum logic [1:0] {
    ATTR_SEL_GRAPHIC = 2'd0,
    ATTR_SEL_FLASH   = 2'd1,
    ATTR_SEL_CLEAR   = 2'd2,
    ATTR_SEL_NONE    = 2'd3
  } attr_sel_e;

  typedef enum logic [CfgIndexW-1:0] {
    CFG_SINGLE_WIDTH   = 2'd0,
    CFG_CURSOR_ENABLE  = 2'd1,
    CFG_CURSOR_ADDRESS = 2'd2
  } cfg_index_e;

  typedef struct packed {
    logic graphic;
    logic flash;
    logic clear;
  } row_attr_t;

  typedef struct packed {
    cell_kind_e          kind;
    logic [PixelW-1:0]   pixels;
    logic                double_width;
  } cell_result_t;

  // every pixel repeated once, msb first
  function automatic logic [PixelW-1:0] double_pixels(input logic [GlyphWidth-1:0] px);
    logic [PixelW-1:0] r;
    r = '0;
    for (int i = 0; i < GlyphWidth; i++) begin
      r[2*i]   = px[i];
      r[2*i+1] = px[i];
    end
    return r;
  endfunction

endpackage

FILE: rtl/crr_if.sv
// crr_if: valid/ready channel interfaces for cell items, results and register writes
// depends on crr_pkg for field widths

interface crr_in_if;
  logic                              valid;
  logic                              ready;
  logic                              cmd;
  logic [crr_pkg::RomAddrW-1:0]      rom_address;
  logic [crr_pkg::RomDataW-1:0]      rom_byte;
  logic [crr_pkg::CharCodeW-1:0]     char_code;
  logic [crr_pkg::CharAddrW-1:0]     char_address;
  logic [crr_pkg::ScanlineW-1:0]     scanline;
  logic                              line_start;
  logic                              flash_phase;

  modport source (output valid, cmd, rom_address, rom_byte, char_code, char_address,
                  scanline, line_start, flash_phase, input ready);
  modport sink   (input valid, cmd, rom_address, rom_byte, char_code, char_address,
                  scanline, line_start, flash_phase, output ready);
endinterface

interface crr_out_if;
  logic                              valid;
  logic                              ready;
  logic [1:0]                        cell_kind;
  logic [crr_pkg::PixelW-1:0]        pixel_bits;
  logic                              double_width;

  modport source (output valid, cell_kind, pixel_bits, double_width, input ready);
  modport sink   (input valid, cell_kind, pixel_bits, double_width, output ready);
endinterface

interface crr_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [crr_pkg::CfgIndexW-1:0]     index;
  logic [crr_pkg::CfgDataW-1:0]      data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/crr_glyph_mem.sv
// crr_glyph_mem: glyph rom storage, one write port and one registered read port
// depends on crr_pkg for the data width

module crr_glyph_mem #(
  parameter int unsigned Depth = crr_pkg::RomDepth
) (
  input  logic                             clk_i,
  input  logic                             we_i,
  input  logic [$clog2(Depth)-1:0]         waddr_i,
  input  logic [crr_pkg::RomDataW-1:0]     wdata_i,
  input  logic                             re_i,
  input  logic [$clog2(Depth)-1:0]         raddr_i,
  output logic [crr_pkg::RomDataW-1:0]     rdata_o
);
  import crr_pkg::*;

  logic [RomDataW-1:0] mem [Depth];
  logic [RomDataW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read data holds while no read is issued
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/crr_cell_decode.sv
// crr_cell_decode: turns a glyph rom byte into a cell result and attribute update
// depends on crr_pkg for types and pixel doubling

module crr_cell_decode (
  input  logic [crr_pkg::RomDataW-1:0] rom_data_i,
  input  logic                         skip_i,
  input  logic                         inverse_i,
  input  logic                         single_width_i,
  input  crr_pkg::row_attr_t           attr_i,
  output crr_pkg::row_attr_t           attr_o,
  output logic                         set_skip_o,
  output crr_pkg::cell_result_t        result_o
);
  import crr_pkg::*;

  logic [GlyphWidth-1:0] px;
  logic                  attr_val;

  assign px       = rom_data_i[GlyphWidth-1:0] ^ {GlyphWidth{inverse_i}};
  assign attr_val = rom_data_i[AttrValBit];

  always_comb begin
    attr_o     = attr_i;
    set_skip_o = 1'b0;
    result_o   = '{kind: KIND_PIXELS, pixels: '0, double_width: 1'b0};
    if (skip_i) begin
      result_o.kind = KIND_SKIP;
    end else if (rom_data_i[AttrCmdBit]) begin
      result_o.kind = KIND_ATTR;
      case (attr_sel_e'(rom_data_i[1:0]))
        ATTR_SEL_GRAPHIC: attr_o.graphic = attr_val;
        ATTR_SEL_FLASH:   attr_o.flash   = attr_val;
        ATTR_SEL_CLEAR:   attr_o.clear   = attr_val;
        default:          attr_o         = attr_i;
      endcase
    end else if (single_width_i) begin
      result_o.pixels = {{(PixelW - GlyphWidth){1'b0}}, px};
    end else begin
      result_o.pixels       = double_pixels(px);
      result_o.double_width = 1'b1;
      set_skip_o            = 1'b1;
    end
  end

endmodule

FILE: rtl/char_rom_row_attribute_renderer_core.sv
// char_rom_row_attribute_renderer_core: text-mode cell renderer, glyph rom with row attributes
// a render cell's rom byte is read when accepted, its result registered when it retires
// throughput: one transaction per cycle; attribute and skip updates of one cell are forwarded
//   into the rom address of the next, so only a result held by a stalled output stops input
// reset: attributes and flags clear at once; single width set; rom undefined until written
// depends on crr_pkg, crr_if, crr_glyph_mem and crr_cell_decode

module char_rom_row_attribute_renderer_core #(
  parameter int unsigned ROM_DEPTH = crr_pkg::RomDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  crr_in_if.sink     in_i,
  crr_cfg_if.sink    cfg_i,
  crr_out_if.source  out_o
);
  import crr_pkg::*;

  localparam int unsigned RomAw = $clog2(ROM_DEPTH);

  // configuration registers
  logic                 single_width_q;
  logic                 cursor_enable_q;
  logic [CharAddrW-1:0] cursor_address_q;

  // row state
  row_attr_t attr_q, attr_d;
  logic      skip_q, skip_d;

  // cell waiting for its rom data
  logic pend_q, pend_d;
  logic pend_skip_q;
  logic pend_inv_q;

  // output register
  logic         out_valid_q;
  cell_result_t out_q;

  // handshake decode
  logic accept, acc_render, acc_write, retire;

  // decode results and forwarded state
  logic [RomDataW-1:0] rom_data;
  row_attr_t           dec_attr;
  logic                dec_set_skip;
  cell_result_t        dec_result;
  row_attr_t           eff_attr, cur_attr;
  logic                eff_skip, cur_skip;

  // rom address generation
  logic [ScanlineW-1:0] row_sel;
  logic [RomAddrW-1:0]  rd_addr;
  logic                 cursor_hit;

  assign retire     = pend_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !pend_q || retire;
  assign accept     = in_i.valid && in_i.ready;
  assign acc_render = accept && in_i.cmd;
  assign acc_write  = accept && !in_i.cmd;

  assign cfg_i.ready = 1'b1;

  crr_glyph_mem #(
    .Depth (ROM_DEPTH)
  ) u_glyph_mem (
    .clk_i   (clk_i),
    .we_i    (acc_write),
    .waddr_i (in_i.rom_address[RomAw-1:0]),
    .wdata_i (in_i.rom_byte),
    .re_i    (acc_render),
    .raddr_i (rd_addr[RomAw-1:0]),
    .rdata_o (rom_data)
  );

  crr_cell_decode u_cell_decode (
    .rom_data_i     (rom_data),
    .skip_i         (pend_skip_q),
    .inverse_i      (pend_inv_q),
    .single_width_i (single_width_q),
    .attr_i         (attr_q),
    .attr_o         (dec_attr),
    .set_skip_o     (dec_set_skip),
    .result_o       (dec_result)
  );

  // state as left by the retiring cell, then the line start clear of the new one
  always_comb begin
    eff_attr = retire ? dec_attr : attr_q;
    eff_skip = (retire && dec_set_skip) || skip_q;
    cur_attr = in_i.line_start ? '0 : eff_attr;
    cur_skip = in_i.line_start ? 1'b0 : eff_skip;
  end

  // row selection: cursor overrides the scanline, flash or clear override both
  always_comb begin
    cursor_hit = cursor_enable_q && (in_i.char_address == cursor_address_q);
    row_sel    = in_i.scanline;
    if (cursor_hit) begin
      row_sel = RowCursor;
    end
    if ((in_i.flash_phase && cur_attr.flash) || cur_attr.clear) begin
      row_sel = RowBlank;
    end
    rd_addr = {cur_attr.graphic, in_i.char_code[CharCodeW-2:0], row_sel};
  end

  always_comb begin
    attr_d = eff_attr;
    skip_d = eff_skip;
    pend_d = pend_q;
    if (retire) begin
      pend_d = 1'b0;
    end
    if (acc_render) begin
      // a set skip flag is consumed by this cell
      attr_d = cur_attr;
      skip_d = 1'b0;
      pend_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attr_q      <= '0;
      skip_q      <= 1'b0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      attr_q <= attr_d;
      skip_q <= skip_d;
      pend_q <= pend_d;
      if (retire) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (acc_render) begin
      pend_skip_q <= cur_skip;
      pend_inv_q  <= in_i.char_code[InverseBit];
    end
    if (retire) begin
      out_q <= dec_result;
    end
  end

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      single_width_q   <= 1'b1;
      cursor_enable_q  <= 1'b0;
      cursor_address_q <= '0;
    end else if (cfg_i.valid && cfg_i.ready) begin
      case (cfg_index_e'(cfg_i.index))
        CFG_SINGLE_WIDTH:   single_width_q   <= cfg_i.data[0];
        CFG_CURSOR_ENABLE:  cursor_enable_q  <= cfg_i.data[0];
        CFG_CURSOR_ADDRESS: cursor_address_q <= cfg_i.data[CharAddrW-1:0];
        default: begin
        end
      endcase
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.cell_kind    = out_q.kind;
  assign out_o.pixel_bits   = out_q.pixels;
  assign out_o.double_width = out_q.double_width;

endmodule
